// File: sv/rleg_pkg.sv
// Shared types and constants for the guarded run-length encoder.
// No dependencies; imported by the step logic, the top level and the checker.
`default_nettype none

package rleg_pkg;

	localparam int WORD_W      = 64;
	localparam int SYMBOL_BITS = 64;
	localparam int COUNT_W     = 33;
	localparam int GUARD_W     = 32;
	localparam int MAX_RES     = 4;
	localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
	localparam int RES_IDX_W   = $clog2(MAX_RES);

	localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(255);
	localparam logic [WORD_W-1:0]  SYM_MASK    = {WORD_W{1'b1}} >> (WORD_W - SYMBOL_BITS);

	typedef enum logic {
		KIND_VALUE  = 1'b0,
		KIND_LENGTH = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] word;
		logic              item_done;
		logic              block_done;
	} res_t;

	typedef struct packed {
		logic               open;
		logic [WORD_W-1:0]  sym;
		logic [COUNT_W-1:0] cnt;
	} run_state_t;

endpackage

`default_nettype wire

// File: sv/rleg_step.sv
// Combinational step of the encoder: run state, one symbol and the guard in,
// next run state and up to four result words out. Depends on rleg_pkg.
`default_nettype none

module rleg_step import rleg_pkg::*; (
	input  run_state_t                 cur,
	input  logic [WORD_W-1:0]          symbol,
	input  logic                       block_end,
	input  logic [GUARD_W-1:0]         guard,
	output run_state_t                 nxt,
	output res_t [MAX_RES-1:0]         res,
	output logic [RES_CNT_W-1:0]       n
);

	logic [WORD_W-1:0]    sym;
	logic [COUNT_W-1:0]   g;
	logic [COUNT_W-1:0]   c1;
	logic [COUNT_W-1:0]   cf;
	logic [COUNT_W-1:0]   cf2;
	logic [RES_IDX_W-1:0] npre;
	logic [RES_IDX_W-1:0] npre1;

	always_comb begin
		sym   = symbol & SYM_MASK;
		g     = (guard == '0) ? COUNT_W'(1) : {1'b0, guard};
		c1    = cur.cnt + COUNT_W'(1);
		cf    = (cur.cnt == '0) ? COUNT_W'(1) : cur.cnt;
		nxt   = cur;
		npre  = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '{kind: KIND_VALUE, word: '0, item_done: 1'b0, block_done: 1'b0};
		end

		if (!cur.open) begin
			nxt.open = 1'b1;
			nxt.sym  = sym;
			nxt.cnt  = COUNT_W'(1);
		end else if (sym == cur.sym) begin
			// A run that grows past the guard sends out a full guard piece.
			if (c1 > g) begin
				res[0].kind = KIND_LENGTH;
				res[0].word = WORD_W'(g);
				npre        = RES_IDX_W'(1);
				nxt.cnt     = COUNT_W'(1);
			end else begin
				nxt.cnt = c1;
			end
		end else begin
			res[0].kind = KIND_VALUE;
			res[0].word = cur.sym & SYM_MASK;
			res[1].kind = KIND_LENGTH;
			res[1].word = WORD_W'(cf - COUNT_W'(1));
			npre        = RES_IDX_W'(2);
			nxt.sym     = sym;
			nxt.cnt     = COUNT_W'(1);
		end

		npre1 = npre + RES_IDX_W'(1);
		cf2   = (nxt.cnt == '0) ? COUNT_W'(1) : nxt.cnt;
		n     = RES_CNT_W'(npre);

		if (block_end) begin
			res[npre].kind        = KIND_VALUE;
			res[npre].word        = nxt.sym & SYM_MASK;
			res[npre1].kind       = KIND_LENGTH;
			res[npre1].word       = WORD_W'(cf2 - COUNT_W'(1));
			res[npre1].block_done = 1'b1;
			n                     = RES_CNT_W'(npre) + RES_CNT_W'(2);
			nxt                   = '0;
		end

		for (int i = 0; i < MAX_RES; i++) begin
			if (RES_CNT_W'(i) == n - RES_CNT_W'(1)) begin
				res[i].item_done = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/run_length_encoder_guarded.sv
// Guarded run-length encoder. A symbol request is accepted in any cycle in which
// at most one result is still pending and being taken; its results appear in the
// cycle after acceptance, one per cycle while res_stall is low, from a four-entry
// output shift register. Items with zero or one result sustain one item per cycle
// while unstalled; an item with more results holds off the next symbol until its last
// result is taken. Reset clears the run state, empties the output and sets guard to 255.
`default_nettype none

module run_length_encoder_guarded import rleg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_valid,
	output logic               sym_stall,
	input  logic [WORD_W-1:0]  symbol,
	input  logic               block_end,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               stream_kind,
	output logic [WORD_W-1:0]  out_word,
	output logic               item_done,
	output logic               block_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [GUARD_W-1:0] cfg_data
);

	run_state_t             state_q;
	run_state_t             state_nxt;
	logic [GUARD_W-1:0]     guard_q;
	res_t [MAX_RES-1:0]     buf_q;
	res_t [MAX_RES-1:0]     res;
	logic [RES_CNT_W-1:0]   rem_q;
	logic [RES_CNT_W-1:0]   n;
	logic                   accept;
	logic                   take;

	rleg_step u_step (
		.cur       (state_q),
		.symbol    (symbol),
		.block_end (block_end),
		.guard     (guard_q),
		.nxt       (state_nxt),
		.res       (res),
		.n         (n)
	);

	assign cfg_ready   = 1'b1;
	assign res_valid   = (rem_q != '0);
	assign take        = res_valid && !res_stall;
	// New results may load only once the pending ones are gone by the next edge.
	assign sym_stall   = (rem_q > RES_CNT_W'(1)) || ((rem_q == RES_CNT_W'(1)) && res_stall);
	assign accept      = sym_valid && !sym_stall;

	assign stream_kind = buf_q[0].kind;
	assign out_word    = buf_q[0].word;
	assign item_done   = buf_q[0].item_done;
	assign block_done  = buf_q[0].block_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			guard_q <= GUARD_RESET;
			rem_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				guard_q <= cfg_data;
			end
			if (accept) begin
				state_q <= state_nxt;
				rem_q   <= n;
			end else if (take) begin
				rem_q <= rem_q - RES_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= res;
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/rleg_checker.sv
// Port-level checker for the guarded run-length encoder, bound to the top level.
// Depends on rleg_pkg and run_length_encoder_guarded.
`default_nettype none

module rleg_checker import rleg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               sym_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic               stream_kind,
	input logic [WORD_W-1:0]  out_word,
	input logic               item_done,
	input logic               block_done
);

	// A stalled result holds still.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_word) && $stable(stream_kind)
			&& $stable(item_done) && $stable(block_done))
		else $error("stalled result changed");

	// The symbol request is only held off while results are pending.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sym_stall |-> res_valid)
		else $error("input stalled with no pending result");

	// More results of the same item follow directly.
	a_item_cont: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !item_done |=> res_valid)
		else $error("item results interrupted");

	// A value word is always followed by its length piece.
	a_value_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && stream_kind == KIND_VALUE |-> !item_done && !block_done)
		else $error("value word ended an item");

	// The block's final word is a length piece that also ends its item.
	a_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && block_done |-> item_done && stream_kind == KIND_LENGTH)
		else $error("block_done on wrong word");

endmodule

bind run_length_encoder_guarded rleg_checker u_rleg_checker (.*);

`default_nettype wire

// File: tb/tb_run_length_encoder_guarded.sv
// Testbench for the guarded run-length encoder: directed runs, then randomized symbol
// streams under three idling mixes, checked word by word against a built-in predictor.
// Depends on rleg_pkg and run_length_encoder_guarded.
`default_nettype none

module tb_run_length_encoder_guarded import rleg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 40;
	localparam int SETTLE_CYC  = 4;

	// Tracks the open run and queues the value and length words that each symbol causes.
	class rle_predictor;
		logic [GUARD_W-1:0] guard;
		logic               run_open;
		logic [WORD_W-1:0]  run_sym;
		logic [COUNT_W-1:0] run_cnt;
		res_t               due_words[$];
		int                 errors;
		int                 n_symbols;
		int                 n_checked;
		int                 n_blocks;
		int                 n_splits;

		function new();
			guard     = GUARD_RESET;
			run_open  = 1'b0;
			run_sym   = '0;
			run_cnt   = '0;
			errors    = 0;
			n_symbols = 0;
			n_checked = 0;
			n_blocks  = 0;
			n_splits  = 0;
		endfunction

		function void set_guard(logic [GUARD_W-1:0] value);
			guard = value;
		endfunction

		function void accept_symbol(logic [WORD_W-1:0] raw, logic last);
			res_t               words[MAX_RES];
			int                 n;
			logic [WORD_W-1:0]  sym;
			logic [COUNT_W-1:0] g;
			n   = 0;
			sym = raw & SYM_MASK;
			// A guard of zero acts as a guard of one.
			g   = (guard == '0) ? COUNT_W'(1) : COUNT_W'(guard);
			n_symbols++;
			if (!run_open) begin
				run_open = 1'b1;
				run_sym  = sym;
				run_cnt  = COUNT_W'(1);
			end else if (sym == run_sym) begin
				run_cnt = run_cnt + COUNT_W'(1);
				if (run_cnt > g) begin
					words[n] = '{KIND_LENGTH, WORD_W'(g), 1'b0, 1'b0};
					n++;
					n_splits++;
					run_cnt = COUNT_W'(1);
				end
			end else begin
				if (run_cnt == '0)
					run_cnt = COUNT_W'(1);
				words[n]     = '{KIND_VALUE, run_sym & SYM_MASK, 1'b0, 1'b0};
				words[n + 1] = '{KIND_LENGTH, WORD_W'(run_cnt - COUNT_W'(1)), 1'b0, 1'b0};
				n += 2;
				run_sym = sym;
				run_cnt = COUNT_W'(1);
			end
			if (last) begin
				if (run_cnt == '0)
					run_cnt = COUNT_W'(1);
				words[n]     = '{KIND_VALUE, run_sym & SYM_MASK, 1'b0, 1'b0};
				words[n + 1] = '{KIND_LENGTH, WORD_W'(run_cnt - COUNT_W'(1)), 1'b0, 1'b1};
				n += 2;
				n_blocks++;
				run_open = 1'b0;
				run_sym  = '0;
				run_cnt  = '0;
			end
			if (n > 0)
				words[n - 1].item_done = 1'b1;
			for (int i = 0; i < n; i++)
				due_words = {due_words, words[i]};
		endfunction

		function void check_word(kind_t kind, logic [WORD_W-1:0] word, logic idone,
				logic bdone);
			res_t want;
			if (due_words.size() == 0) begin
				$error("unexpected result: stream_kind %0d out_word %h", kind, word);
				errors++;
				return;
			end
			want = due_words.pop_front();
			n_checked++;
			if (kind !== want.kind) begin
				$error("stream_kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (word !== want.word) begin
				$error("out_word: expected %h, got %h", want.word, word);
				errors++;
			end
			if (idone !== want.item_done) begin
				$error("item_done: expected %0d, got %0d", want.item_done, idone);
				errors++;
			end
			if (bdone !== want.block_done) begin
				$error("block_done: expected %0d, got %0d", want.block_done, bdone);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               sym_valid;
	logic               sym_stall;
	logic [WORD_W-1:0]  symbol;
	logic               block_end;
	logic               res_valid;
	logic               res_stall;
	logic               stream_kind;
	logic [WORD_W-1:0]  out_word;
	logic               item_done;
	logic               block_done;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [GUARD_W-1:0] cfg_data;

	rle_predictor pred;
	int           send_idle_pct;
	int           recv_idle_pct;
	logic         hold_req;
	int           hold_count;
	int           cycle_count;

	run_length_encoder_guarded i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sym_valid   (sym_valid),
		.sym_stall   (sym_stall),
		.symbol      (symbol),
		.block_end   (block_end),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.stream_kind (stream_kind),
		.out_word    (out_word),
		.item_done   (item_done),
		.block_done  (block_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Output side: random stall, or a long hold-off when one is requested.
	always begin
		@(negedge clk);
		if (hold_req) begin
			res_stall <= 1'b1;
			hold_count++;
			if (hold_count >= LONG_HOLD) begin
				hold_req   = 1'b0;
				hold_count = 0;
			end
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			pred.check_word(kind_t'(stream_kind), out_word, item_done, block_done);
	end

	task automatic send_symbol(input logic [WORD_W-1:0] s, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sym_valid <= 1'b0;
			@(negedge clk);
		end
		sym_valid <= 1'b1;
		symbol    <= s;
		block_end <= last;
		do @(posedge clk); while (sym_stall);
		pred.accept_symbol(s, last);
	endtask

	// Drops the request and waits until every expected word has come out.
	task automatic drain_words();
		@(negedge clk);
		sym_valid <= 1'b0;
		while (pred.due_words.size() != 0)
			@(posedge clk);
	endtask

	// A symbol that only extends a run may still be in flight after the last word.
	task automatic settle();
		drain_words();
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_guard(input logic [GUARD_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		pred.set_guard(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n_items, input logic [GUARD_W-1:0] g,
			input int s_pct, input int r_pct, input int hold_at, input int pause_at);
		logic [WORD_W-1:0] palette[4];
		logic [WORD_W-1:0] cur;
		settle();
		write_guard(g);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		palette[0] = {$urandom, $urandom};
		palette[1] = {$urandom, $urandom};
		palette[2] = '0;
		palette[3] = '1;
		cur = palette[0];
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == pause_at)
				drain_words();
			// Mostly repeat the current symbol so that runs reach the guard.
			if ($urandom_range(99) >= 55) begin
				if ($urandom_range(99) < 70)
					cur = palette[$urandom_range(3)];
				else
					cur = {$urandom, $urandom};
			end
			send_symbol(cur, $urandom_range(99) < 8);
		end
	endtask

	initial begin
		logic [WORD_W-1:0] run_a;
		logic [WORD_W-1:0] run_b;
		pred          = new();
		arst_n        = 1'b0;
		sym_valid     = 1'b0;
		symbol        = '0;
		block_end     = 1'b0;
		res_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		hold_req      = 1'b0;
		hold_count    = 0;
		cycle_count   = 0;
		send_idle_pct = 14;
		recv_idle_pct = 61;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Smallest guard: every repeat splits; a lone symbol with the end flag closes at once.
		write_guard(GUARD_W'(1));
		send_symbol('0, 1'b1);
		send_symbol('1, 1'b0);
		send_symbol('1, 1'b0);
		send_symbol('1, 1'b0);
		send_symbol({WORD_W/2{2'b10}}, 1'b0);
		send_symbol({WORD_W/2{2'b01}}, 1'b1);

		settle();
		write_guard('0);
		send_symbol(WORD_W'(7), 1'b0);
		send_symbol(WORD_W'(7), 1'b0);
		send_symbol(WORD_W'(7), 1'b1);

		settle();
		write_guard('1);
		send_symbol(WORD_W'(9), 1'b0);
		send_symbol(WORD_W'(9), 1'b0);
		send_symbol(WORD_W'(9), 1'b0);
		send_symbol(WORD_W'(10), 1'b1);

		// Lower the guard under an open run of five: its closing piece exceeds the guard.
		run_a = {$urandom, $urandom};
		run_b = ~run_a;
		settle();
		write_guard(GUARD_RESET);
		repeat (5) send_symbol(run_a, 1'b0);
		settle();
		write_guard(GUARD_W'(2));
		send_symbol(run_b, 1'b0);
		send_symbol(run_b, 1'b0);
		send_symbol(run_b, 1'b0);
		send_symbol(run_b, 1'b1);

		random_phase(150, GUARD_W'(3), 14, 61, 50, 110);
		random_phase(150, GUARD_W'(1), 61, 14, -1, 75);
		random_phase(150, GUARD_W'(2), 0, 0, 60, -1);

		settle();
		repeat (10) @(posedge clk);
		$display("Covered %0d symbols in %0d blocks, %0d guard splits, %0d words checked.",
			pred.n_symbols, pred.n_blocks, pred.n_splits, pred.n_checked);
		$display("Guards used: 0, 1, 2, 3, 255 and the 32-bit maximum, with a mid-run drop.");
		if (pred.errors == 0 && pred.due_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
